// ===== rtl/core/mcod_pkg.sv =====
// package for the matrix chain order unit: payload words, queue word, back-end states
// depends on nothing
`timescale 1ns / 1ps

package mcod_pkg;

    localparam int DIMENSION_W = 12;
    localparam int INDEX_W     = 4;
    localparam int SPLIT_W     = 3;
    localparam int COST_W      = 48;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [DIMENSION_W-1:0] dimension;
        logic                   last_dim;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] last_index;
        logic [SPLIT_W-1:0] best_split;
        logic [COST_W-1:0]  min_cost;
        logic               saturated;
        logic               too_many;
        logic               last_result;
    } t_out_word;

    // head of the queue as seen by the back end
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_queue_head;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SHORT,
        ST_PAIR_DI,
        ST_PAIR_DJ,
        ST_SPLIT,
        ST_DRAIN,
        ST_FINISH
    } t_back_state;

endpackage

// ===== rtl/core/mcod_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module mcod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mcod_front.sv =====
// front end: accepts dimension words and queues them for the back end
// depends on mcod_pkg
`timescale 1ns / 1ps

module mcod_front
    import mcod_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_word    i_item,
    output logic        o_busy,
    output t_queue_head o_head,
    input  logic        i_pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_in_word      r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_busy = (r_cnt == CW'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.word  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end

endmodule

// ===== rtl/core/mcod_back.sv =====
// back end: stores dimensions, runs the split search and emits one result per subchain
// depends on mcod_pkg and mcod_ram
`timescale 1ns / 1ps

module mcod_back
    import mcod_pkg::*;
#(
    parameter int MAX_MATRICES = 8,
    parameter int DIM_BITS     = 12,
    parameter int COST_BITS    = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    output logic        o_valid,
    output t_out_word   o_result
);

    localparam int NDIM = MAX_MATRICES + 1;
    localparam int DW   = $clog2(NDIM);
    localparam int IW   = $clog2(MAX_MATRICES + 2);
    localparam int TD   = MAX_MATRICES * MAX_MATRICES;
    localparam int TW   = (TD > 1) ? $clog2(TD) : 1;
    localparam int P2W  = 2 * DIM_BITS;
    localparam int P3W  = 3 * DIM_BITS;
    localparam int PXW  = (P3W > COST_BITS) ? P3W : COST_BITS;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    function automatic logic [TW-1:0] tidx(input logic [IW-1:0] a, input logic [IW-1:0] b);
        tidx = TW'((int'(a) - 1) * MAX_MATRICES + (int'(b) - 1));
    endfunction

    t_back_state r_state, n_state;
    logic [IW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [IW-1:0] r_n, n_n;
    logic [IW-1:0] r_diag, n_diag;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_k, n_k;
    logic [IW-1:0] j;

    logic [DIM_BITS-1:0] r_di;
    logic [DIM_BITS-1:0] r_dj;

    // dimension and cost ram ports
    logic                 dim_we;
    logic [DW-1:0]        dim_waddr;
    logic [DW-1:0]        dim_raddr;
    logic [DIM_BITS-1:0]  dim_wdata;
    logic [DIM_BITS-1:0]  dim_rdata;
    logic [15:0]          dim_ext;
    logic                 cost_we;
    logic [TW-1:0]        cost_waddr;
    logic [TW-1:0]        cost_raddr_a;
    logic [TW-1:0]        cost_raddr_b;
    logic [COST_BITS-1:0] cost_rdata_a;
    logic [COST_BITS-1:0] cost_rdata_b;

    // search pipeline
    logic                 r_s1_v, r_s1_first, r_s1_za, r_s1_zb;
    logic [IW-1:0]        r_s1_k;
    logic                 r_s2_v, r_s2_first;
    logic [IW-1:0]        r_s2_k;
    logic [P2W-1:0]       r_s2_prod;
    logic [COST_BITS-1:0] r_s2_ma, r_s2_mb;
    logic                 r_s3_v, r_s3_first;
    logic [IW-1:0]        r_s3_k;
    logic [P3W-1:0]       r_s3_prod;
    logic [COST_BITS:0]   r_s3_sum;
    logic                 r_s4_v, r_s4_first, r_s4_clip;
    logic [IW-1:0]        r_s4_k;
    logic [COST_BITS-1:0] r_s4_cost;
    logic [COST_BITS-1:0] r_best;
    logic [IW-1:0]        r_best_k;
    logic                 r_best_clip;

    logic                 sum_clip, prod_clip;
    logic [COST_BITS-1:0] sum_sat, prod_sat;
    logic [COST_BITS:0]   total;

    logic      r_out_v, n_out_v;
    t_out_word r_out, n_out;
    logic      pipe_empty;

    assign j       = r_i + r_diag;
    assign dim_ext = 16'(i_head.word.dimension);

    mcod_ram #(.WIDTH(DIM_BITS), .DEPTH(NDIM)) u_dim_ram (
        .i_clk  (i_clk),
        .i_we   (dim_we),
        .i_waddr(dim_waddr),
        .i_wdata(dim_wdata),
        .i_raddr(dim_raddr),
        .o_rdata(dim_rdata)
    );

    // two copies of the cost table give two reads a cycle
    mcod_ram #(.WIDTH(COST_BITS), .DEPTH(TD)) u_cost_ram_a (
        .i_clk  (i_clk),
        .i_we   (cost_we),
        .i_waddr(cost_waddr),
        .i_wdata(r_best),
        .i_raddr(cost_raddr_a),
        .o_rdata(cost_rdata_a)
    );

    mcod_ram #(.WIDTH(COST_BITS), .DEPTH(TD)) u_cost_ram_b (
        .i_clk  (i_clk),
        .i_we   (cost_we),
        .i_waddr(cost_waddr),
        .i_wdata(r_best),
        .i_raddr(cost_raddr_b),
        .o_rdata(cost_rdata_b)
    );

    assign pipe_empty = !r_s1_v && !r_s2_v && !r_s3_v && !r_s4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_diag <= n_diag;
        r_i    <= n_i;
        r_k    <= n_k;
        r_out  <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_n          = r_n;
        n_diag       = r_diag;
        n_i          = r_i;
        n_k          = r_k;
        n_out_v      = 1'b0;
        n_out        = r_out;
        o_pop        = 1'b0;
        dim_we       = 1'b0;
        dim_waddr    = DW'(r_count);
        dim_wdata    = dim_ext[DIM_BITS-1:0];
        dim_raddr    = DW'(r_k);
        cost_we      = 1'b0;
        cost_waddr   = tidx(r_i, j);
        cost_raddr_a = tidx(r_i, r_k);
        cost_raddr_b = tidx(r_k + 1'b1, j);
        unique case (r_state)
            ST_LOAD: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (r_count < IW'(NDIM)) begin
                        dim_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_head.word.last_dim) begin
                        n_n    = n_count - 1'b1;
                        n_diag = IW'(1);
                        n_i    = IW'(1);
                        n_state = (n_n <= IW'(1)) ? ST_SHORT : ST_PAIR_DI;
                    end
                end
            end
            ST_SHORT: begin
                n_out_v           = 1'b1;
                n_out.first_index = INDEX_W'(r_n);
                n_out.last_index  = INDEX_W'(r_n);
                n_out.best_split  = '0;
                n_out.min_cost    = '0;
                n_out.saturated   = 1'b0;
                n_out.too_many    = r_ovf;
                n_out.last_result = 1'b1;
                n_count           = '0;
                n_ovf             = 1'b0;
                n_state           = ST_LOAD;
            end
            ST_PAIR_DI: begin
                dim_raddr = DW'(r_i - 1'b1);
                n_state   = ST_PAIR_DJ;
            end
            ST_PAIR_DJ: begin
                dim_raddr = DW'(j);
                n_k       = r_i;
                n_state   = ST_SPLIT;
            end
            ST_SPLIT: begin
                n_k = r_k + 1'b1;
                if (r_k == j - 1'b1) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cost_we           = 1'b1;
                n_out_v           = 1'b1;
                n_out.first_index = INDEX_W'(r_i);
                n_out.last_index  = INDEX_W'(j);
                n_out.best_split  = SPLIT_W'(r_best_k);
                n_out.min_cost    = COST_W'(r_best);
                n_out.saturated   = r_best_clip;
                n_out.too_many    = r_ovf;
                n_out.last_result = (r_diag == r_n - 1'b1);
                n_state           = ST_PAIR_DI;
                if (j == r_n) begin
                    if (r_diag == r_n - 1'b1) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_diag = r_diag + 1'b1;
                        n_i    = IW'(1);
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // saturating combine of the stage three sums
    always_comb begin
        sum_clip  = r_s3_sum[COST_BITS];
        sum_sat   = sum_clip ? COST_MAX : r_s3_sum[COST_BITS-1:0];
        prod_clip = PXW'(r_s3_prod) > PXW'(COST_MAX);
        prod_sat  = prod_clip ? COST_MAX : COST_BITS'(r_s3_prod);
        total     = {1'b0, sum_sat} + {1'b0, prod_sat};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == ST_SPLIT);
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PAIR_DJ) begin
            r_di <= dim_rdata;
        end
        // first split cycle still sees d[j], issued in the pair setup
        if (r_state == ST_SPLIT && r_k == r_i) begin
            r_dj <= dim_rdata;
        end
        r_s1_k     <= r_k;
        r_s1_first <= (r_k == r_i);
        r_s1_za    <= (r_k == r_i);
        r_s1_zb    <= (r_k + 1'b1 == j);
        r_s2_k     <= r_s1_k;
        r_s2_first <= r_s1_first;
        r_s2_prod  <= P2W'(r_di) * P2W'(dim_rdata);
        r_s2_ma    <= r_s1_za ? '0 : cost_rdata_a;
        r_s2_mb    <= r_s1_zb ? '0 : cost_rdata_b;
        r_s3_k     <= r_s2_k;
        r_s3_first <= r_s2_first;
        r_s3_prod  <= P3W'(r_s2_prod) * P3W'(r_dj);
        r_s3_sum   <= {1'b0, r_s2_ma} + {1'b0, r_s2_mb};
        r_s4_k     <= r_s3_k;
        r_s4_first <= r_s3_first;
        r_s4_clip  <= sum_clip || prod_clip || total[COST_BITS];
        r_s4_cost  <= total[COST_BITS] ? COST_MAX : total[COST_BITS-1:0];
        // first minimum wins on a tie
        if (r_s4_v && (r_s4_first || r_s4_cost < r_best)) begin
            r_best      <= r_s4_cost;
            r_best_k    <= r_s4_k;
            r_best_clip <= r_s4_clip;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

// ===== rtl/core/matrix_chain_order_dp_unit.sv =====
// top level of the matrix chain order unit: front queue plus dynamic programming back end
// depends on mcod_pkg, mcod_front, mcod_back (and mcod_ram through the back end)
`timescale 1ns / 1ps

//  channel   | handshake                  | word
//  ----------+----------------------------+--------------------------------------
//  dimension | start in, busy out         | i_item: dimension, last_dim
//  result    | o_result_strobe out        | o_result: indices, split, cost, flags
//
//  each dimension word is taken into a two-word queue; busy rises only when
//  the queue is full, so words keep coming while the back end works
//  for each subchain i..j the back end makes two pair setup reads of the single
//  dimension ram port, runs one split per cycle, drains the multiply/add pipeline
//  and then writes the cost and issues the result
//  results leave one cycle each on the strobe and the receiver cannot stall them
//  reset is synchronous and active low; it empties the queue and clears the chain count

module matrix_chain_order_dp_unit
    import mcod_pkg::*;
#(
    parameter int MAX_MATRICES = 8,
    parameter int DIM_BITS     = 12,
    parameter int COST_BITS    = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_item,
    output logic      o_result_strobe,
    output t_out_word o_result
);

    t_queue_head head;
    logic        pop;

    // front: accepts and queues dimension words
    mcod_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_item (i_item),
        .o_busy (busy),
        .o_head (head),
        .i_pop  (pop)
    );

    // back: dimension store, split search, result sequencing
    mcod_back #(
        .MAX_MATRICES(MAX_MATRICES),
        .DIM_BITS    (DIM_BITS),
        .COST_BITS   (COST_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_result_strobe),
        .o_result(o_result)
    );

    // subchain indices never run backwards
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> o_result.first_index <= o_result.last_index)
        else $error("result with first index above last index");

    // only the whole-chain result may cover a single matrix or none
    a_inner_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe && !o_result.last_result |->
            o_result.first_index < o_result.last_index)
        else $error("inner result does not span two matrices");

    // the queue fills only through an accepted word
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a word offered");

endmodule
